/* sv/srp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

    // history geometry
    localparam int DEPTH       = 16;
    localparam int DATA_W      = 32;
    localparam int LIM_W       = 5;
    localparam int LIMIT_RESET = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int PH_SLOTS    = 2 * DEPTH;
    localparam int PH_IDX_W    = $clog2(PH_SLOTS);

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic {
        CMD_ADD     = 1'b0,
        CMD_PREDICT = 1'b1
    } t_cmd;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_INS,
        ST_P_STRIDE,
        ST_P_RUN,
        ST_P_GEN,
        ST_P_CHK,
        ST_P_KEEP,
        ST_P_END
    } t_state;

    // sequencer to history store
    typedef struct packed {
        logic                req_push;
        logic                ph_push;
        logic [IDX_W-1:0]    req_idx;
        logic [PH_IDX_W-1:0] ph_idx;
        t_word               req_data;
        t_word               ph_data;
    } t_hist_cmd;

    // sequencer to output register
    typedef struct packed {
        logic  push;
        t_word blk;
        logic  last;
        logic  empty;
    } t_out_push;

    // zero reads as one, anything past the store depth as the depth
    function automatic t_cnt eff_limit(input logic [LIM_W-1:0] v);
        t_cnt r;
        if (v == '0) begin
            r = t_cnt'(1);
        end else if (v > DEPTH) begin
            r = t_cnt'(DEPTH);
        end else begin
            r = t_cnt'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/srp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srp_in_if;
    import srp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [DATA_W-1:0] block_number;
    logic                     continue_mode;

    modport source (output valid, command, block_number, continue_mode, input ready);
    modport sink   (input valid, command, block_number, continue_mode, output ready);
endinterface

`default_nettype wire

/* sv/srp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srp_out_if;
    import srp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] predicted_block;
    logic                     last_of_run;
    logic                     empty_answer;

    modport source (output valid, predicted_block, last_of_run, empty_answer, input ready);
    modport sink   (input valid, predicted_block, last_of_run, empty_answer, output ready);
endinterface

`default_nettype wire

/* sv/stride_readahead_predictor_top.sv */
// Stride read-ahead predictor.
// i_req carries words of command, block_number and continue_mode; a word is
// taken when valid and ready are both high. An add word (command 0) files a
// block number in the request history and gives no result. A predict word
// (command 1) gives one to fifteen words on o_rsp, the last flagged by
// last_of_run; an answer with nothing to predict is one word with
// empty_answer set and predicted_block zero.
// i_cfg_we with i_cfg_wdata writes history_limit; write it only while idle.
// Timing: one shared adder/comparator walks the histories one entry a cycle;
// ready is low from acceptance until the word is finished.
// Add: held entries are compared in turn, newest first (up to 16), then
// a new number is inserted; a repeated number stops at the match.
// Predict: with two or more entries the stride of the two newest is taken
// and each further entry that keeps it adds a prediction; in continue mode
// each prediction is compared with up to 16 past ones and dropped on a match.
// A word waits in the sequencer until the next one is kept or the answer
// ends; a single output register holds the offered word, and a stalled
// receiver holds the sequencer without losing or repeating.
// Reset (synchronous, active low) empties both histories and sets the
// limit to 16; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stride_readahead_predictor_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    srp_in_if.sink                    i_req,
    srp_out_if.source                 o_rsp,
    input  wire                       i_cfg_we,
    input  wire [srp_pkg::LIM_W-1:0]  i_cfg_wdata
);
    import srp_pkg::*;

    logic [LIM_W-1:0] r_limit;
    logic             r_out_valid;
    t_word            r_out_blk;
    logic             r_out_last, r_out_empty;

    logic      out_free;
    t_out_push out_push;
    t_hist_cmd hist_cmd;
    t_word     req_rd, req_h0, req_h1, ph_rd;

    srp_hist u_hist (
        .i_clk    (i_clk),
        .i_cmd    (hist_cmd),
        .o_req_rd (req_rd),
        .o_req_h0 (req_h0),
        .o_req_h1 (req_h1),
        .o_ph_rd  (ph_rd)
    );

    srp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_limit    (r_limit),
        .i_out_free (out_free),
        .o_out      (out_push),
        .o_hist     (hist_cmd),
        .i_req_rd   (req_rd),
        .i_req_h0   (req_h0),
        .i_req_h1   (req_h1),
        .i_ph_rd    (ph_rd)
    );

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // output register
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_push.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push.push) begin
            r_out_blk   <= out_push.blk;
            r_out_last  <= out_push.last;
            r_out_empty <= out_push.empty;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.predicted_block = $signed(r_out_blk);
    assign o_rsp.last_of_run     = r_out_last;
    assign o_rsp.empty_answer    = r_out_empty;

endmodule

`default_nettype wire

/* sv/srp_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module srp_alu (
    input  wire srp_pkg::t_alu_op i_op,
    input  wire srp_pkg::t_word   i_a,
    input  wire srp_pkg::t_word   i_b,
    input  wire srp_pkg::t_word   i_c,
    output srp_pkg::t_word        o_sum,
    output logic                  o_eq
);
    import srp_pkg::*;

    // one wrapping adder, shared by the scan, stride, run, generate and check steps
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_sum = i_a + i_b;
            ALU_SUB: o_sum = i_a - i_b;
            default: o_sum = i_a - i_b;
        endcase
    end

    // result against the compare operand (zero for a match test)
    assign o_eq = (o_sum == i_c);

endmodule

`default_nettype wire

/* sv/srp_hist.sv */
`timescale 1ns / 1ps
`default_nettype none

module srp_hist (
    input  wire                       i_clk,
    input  wire srp_pkg::t_hist_cmd   i_cmd,
    output srp_pkg::t_word            o_req_rd,
    output srp_pkg::t_word            o_req_h0,
    output srp_pkg::t_word            o_req_h1,
    output srp_pkg::t_word            o_ph_rd
);
    import srp_pkg::*;

    // newest first; the prediction line is twice as long so old entries
    // survive while new ones are pushed in front during an answer
    t_word r_req [DEPTH];
    t_word r_ph  [PH_SLOTS];

    // request history shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_push) begin
            r_req[0] <= i_cmd.req_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_req[i] <= r_req[i-1];
            end
        end
    end

    // past prediction shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.ph_push) begin
            r_ph[0] <= i_cmd.ph_data;
            for (int i = 1; i < PH_SLOTS; i++) begin
                r_ph[i] <= r_ph[i-1];
            end
        end
    end

    // read ports
    assign o_req_rd = r_req[i_cmd.req_idx];
    assign o_req_h0 = r_req[0];
    assign o_req_h1 = r_req[1];
    assign o_ph_rd  = r_ph[i_cmd.ph_idx];

endmodule

`default_nettype wire

/* sv/srp_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module srp_seq (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    srp_in_if.sink                    i_req,
    input  wire [srp_pkg::LIM_W-1:0]  i_limit,
    input  wire                       i_out_free,
    output srp_pkg::t_out_push        o_out,
    output srp_pkg::t_hist_cmd        o_hist,
    input  wire srp_pkg::t_word       i_req_rd,
    input  wire srp_pkg::t_word       i_req_h0,
    input  wire srp_pkg::t_word       i_req_h1,
    input  wire srp_pkg::t_word       i_ph_rd
);
    import srp_pkg::*;

    t_state  r_state, n_state;
    t_word   r_num, r_val, r_d, r_prev, r_pend;
    logic    r_cont, r_have_pend;
    t_cnt    r_rc, r_pc;
    t_cnt    r_idx, r_npred, r_gen, r_kept, r_scan;

    t_cnt             lim;
    t_cnt             idx_inc, scan_inc;
    logic [CNT_W:0]   rc_inc, ph_total;
    logic             accept, keep_go, gen_done;

    t_alu_op alu_op;
    t_word   alu_a, alu_b, alu_c, alu_sum;
    logic    alu_eq;

    srp_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_sum (alu_sum),
        .o_eq  (alu_eq)
    );

    assign lim         = eff_limit(i_limit);
    assign i_req.ready = i_rst_n && (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign idx_inc     = r_idx + t_cnt'(1);
    assign scan_inc    = r_scan + t_cnt'(1);
    assign rc_inc      = {1'b0, r_rc} + (CNT_W+1)'(1);
    assign ph_total    = {1'b0, r_kept} + {1'b0, r_pc};
    // a held word goes out when a newer one is kept, so the slot must be free
    assign keep_go     = !r_have_pend || i_out_free;
    assign gen_done    = (r_gen == r_npred);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.command == CMD_PREDICT) begin
                        if (r_rc == '0) begin
                            n_state = ST_P_END;
                        end else if (r_rc == t_cnt'(1)) begin
                            n_state = ST_P_GEN;
                        end else begin
                            n_state = ST_P_STRIDE;
                        end
                    end else if (r_rc == '0) begin
                        n_state = ST_ADD_INS;
                    end else begin
                        n_state = ST_ADD_SCAN;
                    end
                end
            end
            ST_ADD_SCAN: begin
                if (alu_eq) begin
                    n_state = ST_IDLE;
                end else if (idx_inc == r_rc) begin
                    n_state = ST_ADD_INS;
                end
            end
            ST_ADD_INS:  n_state = ST_IDLE;
            ST_P_STRIDE: n_state = ST_P_RUN;
            ST_P_RUN: begin
                if (r_idx == r_rc || !alu_eq) begin
                    n_state = ST_P_GEN;
                end
            end
            ST_P_GEN: begin
                n_state = (r_cont && r_pc != '0) ? ST_P_CHK : ST_P_KEEP;
            end
            ST_P_CHK: begin
                if (alu_eq) begin
                    n_state = gen_done ? ST_P_END : ST_P_GEN;
                end else if (scan_inc == r_pc) begin
                    n_state = ST_P_KEEP;
                end
            end
            ST_P_KEEP: begin
                if (keep_go) begin
                    n_state = gen_done ? ST_P_END : ST_P_GEN;
                end
            end
            ST_P_END: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // unit operands, store commands and result pushes
    always_comb begin
        alu_op          = ALU_SUB;
        alu_a           = i_req_rd;
        alu_b           = r_num;
        alu_c           = '0;
        o_hist.req_push = 1'b0;
        o_hist.ph_push  = 1'b0;
        o_hist.req_idx  = r_idx[IDX_W-1:0];
        o_hist.ph_idx   = PH_IDX_W'(r_kept) + PH_IDX_W'(r_scan);
        o_hist.req_data = r_num;
        o_hist.ph_data  = r_val;
        o_out.push      = 1'b0;
        o_out.blk       = r_pend;
        o_out.last      = 1'b0;
        o_out.empty     = 1'b0;
        unique case (r_state)
            ST_ADD_INS:  o_hist.req_push = 1'b1;
            ST_P_STRIDE: begin
                alu_a = i_req_h0;
                alu_b = i_req_h1;
            end
            ST_P_RUN: begin
                alu_a = r_prev;
                alu_b = i_req_rd;
                alu_c = r_d;
            end
            ST_P_GEN: begin
                alu_op = ALU_ADD;
                alu_a  = r_val;
                alu_b  = r_d;
            end
            ST_P_CHK: begin
                alu_a = i_ph_rd;
                alu_b = r_val;
            end
            ST_P_KEEP: begin
                if (keep_go) begin
                    o_hist.ph_push = 1'b1;
                    o_out.push     = r_have_pend;
                end
            end
            ST_P_END: begin
                o_out.push  = i_out_free;
                o_out.blk   = r_have_pend ? r_pend : '0;
                o_out.last  = 1'b1;
                o_out.empty = !r_have_pend;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rc        <= '0;
            r_pc        <= '0;
            r_have_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_have_pend <= 1'b0;
            end
            if (r_state == ST_ADD_INS) begin
                r_rc <= (rc_inc > {1'b0, lim}) ? lim : r_rc + t_cnt'(1);
            end
            if (r_state == ST_P_KEEP && keep_go) begin
                r_have_pend <= 1'b1;
            end
            if (r_state == ST_P_END && i_out_free) begin
                r_pc <= (ph_total > {1'b0, lim}) ? lim : ph_total[CNT_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num   <= t_word'(i_req.block_number);
            r_cont  <= i_req.continue_mode;
            r_idx   <= (i_req.command == CMD_PREDICT) ? t_cnt'(2) : '0;
            r_val   <= i_req_h0;
            r_prev  <= i_req_h1;
            r_d     <= t_word'(1);
            r_npred <= t_cnt'(1);
            r_gen   <= '0;
            r_kept  <= '0;
            r_scan  <= '0;
        end
        unique case (r_state)
            ST_ADD_SCAN: r_idx <= idx_inc;
            ST_P_STRIDE: r_d   <= alu_sum;
            ST_P_RUN: begin
                if (r_idx != r_rc && alu_eq) begin
                    r_npred <= r_npred + t_cnt'(1);
                    r_prev  <= i_req_rd;
                    r_idx   <= idx_inc;
                end
            end
            ST_P_GEN: begin
                r_val  <= alu_sum;
                r_gen  <= r_gen + t_cnt'(1);
                r_scan <= '0;
            end
            ST_P_CHK: r_scan <= scan_inc;
            ST_P_KEEP: begin
                if (keep_go) begin
                    r_pend <= r_val;
                    r_kept <= r_kept + t_cnt'(1);
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // never load the output register while it still holds a word
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.push |-> i_out_free)
        else $error("result pushed into a full output register");

    // an answer never keeps more words than it generated
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P_END) |-> (r_kept <= r_npred))
        else $error("more predictions kept than generated");

    // the closing word returns the sequencer to idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P_END && i_out_free) |=> (r_state == ST_IDLE))
        else $error("answer did not close");

    // histories stay within the store
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc <= t_cnt'(DEPTH)) && (r_pc <= t_cnt'(DEPTH)))
        else $error("history count beyond store depth");
`endif

endmodule

`default_nettype wire
